### rtl/chd_pkg.sv
// Shared types, constants and a byte decode helper for the chunked body decoder.
`default_nettype none

package chd_pkg;

  localparam int SizeBits = 32;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CaseBit   = 8'h20;
  localparam logic [4:0] HexNone   = 5'd16;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SIZE    = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_END_CR  = 3'd4,
    PH_END_LF  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       chunk_last_byte;
    status_t    status;
  } res_t;

  // Hex digit value (either case), HexNone when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] dig;
    logic [7:0] let_off;
    dig     = b - CharZero;
    let_off = (b | CaseBit) - CharLowA;
    if (dig <= 8'd9) begin
      return dig[4:0];
    end else if (let_off <= 8'd5) begin
      return 5'd10 + let_off[4:0];
    end else begin
      return HexNone;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/http_chunked_body_decoder_core.sv
// Top level of the chunked body decoder: input register, parser, result register.
//
//   channel | signals                                   | carries
//   --------+-------------------------------------------+--------------------------
//   in      | in_valid, in_ready, in_byte               | one raw body byte
//   out     | out_valid, out_ready, payload_valid,      | one result per byte
//           | payload_byte, chunk_last_byte, status     |
//
// One byte per clock sustained while out_ready stays high; a byte passes through the
// input register, then parser logic into the result register.
// Synchronous reset puts the parser back to expecting the first size digit.
// A stall on out holds the result register and then the input register;
// in_ready drops only when both are full and out_ready is low.
`default_nettype none

module http_chunked_body_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            payload_valid,
  output logic [7:0]      payload_byte,
  output logic            chunk_last_byte,
  output logic [1:0]      status
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s2_valid;
  chd_pkg::res_t s2_res;
  chd_pkg::res_t res;
  logic          s2_free;
  logic          s1_go;
  logic          in_take;

  assign s2_free  = !s2_valid || out_ready;
  assign s1_go    = s1_valid && s2_free;
  assign in_ready = !s1_valid || s1_go;
  assign in_take  = in_valid && in_ready;

  chd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .in_byte (s1_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_go);
      s2_valid <= s1_go || (s2_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
    end
    if (s1_go) begin
      s2_res <= res;
    end
  end

  assign out_valid       = s2_valid;
  assign payload_valid   = s2_res.payload_valid;
  assign payload_byte    = s2_res.payload_byte;
  assign chunk_last_byte = s2_res.chunk_last_byte;
  assign status          = s2_res.status;

endmodule

`default_nettype wire

### rtl/chd_parser.sv
// Chunk framing state machine: size parse, payload count, CR LF checks.
`default_nettype none

module chd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    in_byte,
  output chd_pkg::res_t      res
);

  chd_pkg::phase_t                phase, phase_next;
  logic [chd_pkg::SizeBits-1:0]   remaining, remaining_next;
  logic                           final_chunk_seen, final_chunk_seen_next;
  logic                           error_flag, error_flag_next;
  logic                           done_flag, done_flag_next;

  logic [4:0]                     hex_d;
  logic                           is_hex;
  logic                           size_room;
  logic [chd_pkg::SizeBits-1:0]   rem_dec;

  assign hex_d     = chd_pkg::hex_value(in_byte);
  assign is_hex    = (hex_d != chd_pkg::HexNone);
  // remaining < 2^(SizeBits-4): top nibble clear
  assign size_room = (remaining[chd_pkg::SizeBits-1 -: 4] == 4'd0);
  assign rem_dec   = remaining - chd_pkg::SizeBits'(1);

  // next state
  always_comb begin
    phase_next            = phase;
    remaining_next        = remaining;
    final_chunk_seen_next = final_chunk_seen;
    error_flag_next       = error_flag;
    done_flag_next        = done_flag;
    if (!error_flag && !done_flag) begin
      case (phase)
        chd_pkg::PH_START: begin
          if (is_hex) begin
            remaining_next = chd_pkg::SizeBits'(hex_d[3:0]);
            phase_next     = chd_pkg::PH_SIZE;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        chd_pkg::PH_SIZE: begin
          if (is_hex) begin
            if (size_room) begin
              remaining_next = {remaining[chd_pkg::SizeBits-5:0], hex_d[3:0]};
            end else begin
              error_flag_next = 1'b1;
            end
          end else if (in_byte == chd_pkg::CharCr) begin
            phase_next = chd_pkg::PH_SIZE_LF;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        chd_pkg::PH_SIZE_LF: begin
          if (in_byte == chd_pkg::CharLf) begin
            if (remaining != '0) begin
              phase_next = chd_pkg::PH_DATA;
            end else begin
              final_chunk_seen_next = 1'b1;
              phase_next            = chd_pkg::PH_END_CR;
            end
          end else begin
            error_flag_next = 1'b1;
          end
        end
        chd_pkg::PH_DATA: begin
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = chd_pkg::PH_END_CR;
          end
        end
        chd_pkg::PH_END_CR: begin
          if (in_byte == chd_pkg::CharCr) begin
            phase_next = chd_pkg::PH_END_LF;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        chd_pkg::PH_END_LF: begin
          if (in_byte == chd_pkg::CharLf) begin
            if (final_chunk_seen) begin
              done_flag_next = 1'b1;
            end else begin
              phase_next = chd_pkg::PH_START;
            end
          end else begin
            error_flag_next = 1'b1;
          end
        end
        default: begin
          error_flag_next = 1'b1;
        end
      endcase
    end
  end

  // result for this byte
  always_comb begin
    res.payload_valid   = 1'b0;
    res.payload_byte    = 8'h00;
    res.chunk_last_byte = 1'b0;
    if (!error_flag && !done_flag && phase == chd_pkg::PH_DATA) begin
      res.payload_valid   = 1'b1;
      res.payload_byte    = in_byte;
      res.chunk_last_byte = (rem_dec == '0);
    end
    if (error_flag_next) begin
      res.status = chd_pkg::ST_ERR;
    end else if (done_flag_next) begin
      res.status = chd_pkg::ST_DONE;
    end else begin
      res.status = chd_pkg::ST_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= chd_pkg::PH_START;
      remaining        <= '0;
      final_chunk_seen <= 1'b0;
      error_flag       <= 1'b0;
      done_flag        <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      remaining        <= remaining_next;
      final_chunk_seen <= final_chunk_seen_next;
      error_flag       <= error_flag_next;
      done_flag        <= done_flag_next;
    end
  end

endmodule

`default_nettype wire

### rtl/chd_checker.sv
// Port-level checks on the decoder's result stream, bound to the top level.
`default_nettype none

module chd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       payload_valid,
  input wire logic [7:0] payload_byte,
  input wire logic       chunk_last_byte,
  input wire logic [1:0] status
);

  logic err_seen;
  logic done_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen  <= 1'b0;
      done_seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (status == chd_pkg::ST_ERR) begin
        err_seen <= 1'b1;
      end
      if (status == chd_pkg::ST_DONE) begin
        done_seen <= 1'b1;
      end
    end
  end

  // error is sticky over delivered results
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err_seen && out_valid) |-> (status == chd_pkg::ST_ERR))
    else $error("status left error");

  // completion is sticky and never followed by anything else
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (done_seen && out_valid) |-> (status == chd_pkg::ST_DONE))
    else $error("status left done");

  // payload only while the body is still in progress
  a_payload_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_valid) |-> (status == chd_pkg::ST_BUSY))
    else $error("payload with final status");

  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chunk_last_byte) |-> payload_valid)
    else $error("chunk end flag without payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(payload_byte)))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder_core chd_checker u_chd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .payload_valid   (payload_valid),
  .payload_byte    (payload_byte),
  .chunk_last_byte (chunk_last_byte),
  .status          (status)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for http_chunked_body_decoder_core: chunked byte stream in, decoded results checked.
module tb;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned BodyBytes   = 1500;

  // how the single body of the run is terminated
  typedef enum int {
    END_DONE,
    END_EMPTY_SIZE,
    END_STRAY_IN_SIZE,
    END_OVERFLOW,
    END_SIZE_NO_LF,
    END_DATA_NO_CR,
    END_DATA_NO_LF,
    END_TRAILER
  } body_end_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       chunk_last_byte;
  logic [1:0] status;

  logic [7:0]    wire_bytes_q[$];
  chd_pkg::res_t decoded_q[$];

  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned n_in_taken = 0;
  int unsigned n_out_taken = 0;
  int unsigned n_fail = 0;
  int unsigned idle_cycles = 0;

  // parser state mirror, reset values
  chd_pkg::phase_t              ph = chd_pkg::PH_START;
  logic [chd_pkg::SizeBits-1:0] rem_count = '0;
  logic                         zero_chunk = 1'b0;
  logic                         err_seen = 1'b0;
  logic                         body_done = 1'b0;

  http_chunked_body_decoder_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_valid   (payload_valid),
    .payload_byte    (payload_byte),
    .chunk_last_byte (chunk_last_byte),
    .status          (status)
  );

  always #6 clk = ~clk;

  // 16 means not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] folded;
    folded = b | chd_pkg::CaseBit;
    if (b >= chd_pkg::CharZero && b <= chd_pkg::CharZero + 8'd9) begin
      return 5'(b - chd_pkg::CharZero);
    end else if (folded >= chd_pkg::CharLowA && folded <= chd_pkg::CharLowA + 8'd5) begin
      return 5'(folded - chd_pkg::CharLowA + 8'd10);
    end
    return chd_pkg::HexNone;
  endfunction

  function automatic chd_pkg::res_t decode_byte(input logic [7:0] b);
    chd_pkg::res_t r;
    logic [4:0]    dg;
    r = '0;
    dg = hex_nibble(b);
    if (!err_seen && !body_done) begin
      case (ph)
        chd_pkg::PH_START: begin
          if (dg != chd_pkg::HexNone) begin
            rem_count = chd_pkg::SizeBits'(dg[3:0]);
            ph = chd_pkg::PH_SIZE;
          end else begin
            err_seen = 1'b1;
          end
        end
        chd_pkg::PH_SIZE: begin
          if (dg != chd_pkg::HexNone) begin
            // another digit only fits while the top nibble is clear
            if (rem_count[chd_pkg::SizeBits-1 -: 4] == 4'h0) begin
              rem_count = {rem_count[chd_pkg::SizeBits-5:0], dg[3:0]};
            end else begin
              err_seen = 1'b1;
            end
          end else if (b == chd_pkg::CharCr) begin
            ph = chd_pkg::PH_SIZE_LF;
          end else begin
            err_seen = 1'b1;
          end
        end
        chd_pkg::PH_SIZE_LF: begin
          if (b != chd_pkg::CharLf) begin
            err_seen = 1'b1;
          end else if (rem_count != '0) begin
            ph = chd_pkg::PH_DATA;
          end else begin
            zero_chunk = 1'b1;
            ph = chd_pkg::PH_END_CR;
          end
        end
        chd_pkg::PH_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          rem_count = rem_count - 1'b1;
          if (rem_count == '0) begin
            r.chunk_last_byte = 1'b1;
            ph = chd_pkg::PH_END_CR;
          end
        end
        chd_pkg::PH_END_CR: begin
          if (b == chd_pkg::CharCr) ph = chd_pkg::PH_END_LF;
          else err_seen = 1'b1;
        end
        chd_pkg::PH_END_LF: begin
          if (b != chd_pkg::CharLf) err_seen = 1'b1;
          else if (zero_chunk) body_done = 1'b1;
          else ph = chd_pkg::PH_START;
        end
        default: err_seen = 1'b1;
      endcase
    end
    r.status = err_seen ? chd_pkg::ST_ERR : (body_done ? chd_pkg::ST_DONE : chd_pkg::ST_BUSY);
    return r;
  endfunction

  // mostly short gaps, a few long ones; none while quiet is set
  function automatic int unsigned idle_len(input bit quiet);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return chd_pkg::CharZero + v;
    if ($urandom_range(0, 1) == 0) return chd_pkg::CharLowA + v - 8'd10;
    return (chd_pkg::CharLowA & ~chd_pkg::CaseBit) + v - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte(input bit allow_cr);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (hex_nibble(b) != chd_pkg::HexNone || (!allow_cr && b == chd_pkg::CharCr));
    return b;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == avoid);
    return b;
  endfunction

  task automatic push_size(input logic [31:0] n);
    logic [3:0]  digits[$];
    int unsigned pad;
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    do begin
      digits.push_front(n[3:0]);
      n = n >> 4;
    end while (n != 0);
    repeat (pad) digits.push_front(4'h0);
    foreach (digits[k]) wire_bytes_q.push_back(hex_char(digits[k]));
  endtask

  task automatic push_crlf();
    wire_bytes_q.push_back(chd_pkg::CharCr);
    wire_bytes_q.push_back(chd_pkg::CharLf);
  endtask

  task automatic push_payload(input int unsigned n);
    repeat (n) wire_bytes_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_chunk(input int unsigned n);
    push_size(n);
    push_crlf();
    push_payload(n);
    push_crlf();
  endtask

  function automatic int unsigned chunk_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 16);
    if (pick < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 300);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        decoded_q.push_back(decode_byte(in_byte));
        n_in_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (wire_bytes_q.size() != 0) begin
          in_valid <= 1'b1;
          in_byte <= wire_bytes_q.pop_front();
          in_gap <= idle_len((n_in_taken / 150) % 3 == 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    chd_pkg::res_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_out_taken++;
        if (decoded_q.size() == 0) begin
          $error("result with none expected: payload_valid %0b status %0d",
                 payload_valid, status);
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          if (payload_valid !== want.payload_valid) begin
            $error("payload_valid exp %0b got %0b", want.payload_valid, payload_valid);
            n_fail++;
          end
          if (payload_byte !== want.payload_byte) begin
            $error("payload_byte exp %02h got %02h", want.payload_byte, payload_byte);
            n_fail++;
          end
          if (chunk_last_byte !== want.chunk_last_byte) begin
            $error("chunk_last_byte exp %0b got %0b", want.chunk_last_byte, chunk_last_byte);
            n_fail++;
          end
          if (status !== want.status) begin
            $error("status exp %0d got %0d", want.status, status);
            n_fail++;
          end
        end
      end
      if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        out_gap <= idle_len((n_out_taken / 150) % 3 == 1);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    body_end_t ending;

    // directed opening: payload extremes, leading zeros
    push_size(1);
    push_crlf();
    wire_bytes_q.push_back(8'h00);
    push_crlf();
    wire_bytes_q.push_back(chd_pkg::CharZero);
    push_size(1);
    push_crlf();
    wire_bytes_q.push_back(8'hFF);
    push_crlf();
    push_size(2);
    push_crlf();
    wire_bytes_q.push_back(8'h80);
    wire_bytes_q.push_back(8'h7F);
    push_crlf();

    while (wire_bytes_q.size() < BodyBytes) push_chunk(chunk_len());

    // the body can end only once per run, so the seed picks how
    ending = body_end_t'($urandom_range(END_DONE, END_TRAILER));
    case (ending)
      END_DONE: begin
        push_size(0);
        push_crlf();
        push_crlf();
      end
      END_EMPTY_SIZE: wire_bytes_q.push_back(non_hex_byte(1'b1));
      END_STRAY_IN_SIZE: begin
        push_size($urandom_range(1, 15));
        wire_bytes_q.push_back(($urandom_range(0, 1) == 0) ? 8'h3B : non_hex_byte(1'b0));
      end
      END_OVERFLOW: begin
        // largest value that still takes a digit, one digit, then one too many
        push_size(32'h0FFF_FFFF);
        wire_bytes_q.push_back(hex_char(4'($urandom_range(0, 15))));
        wire_bytes_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      END_SIZE_NO_LF: begin
        push_size(3);
        wire_bytes_q.push_back(chd_pkg::CharCr);
        wire_bytes_q.push_back(byte_other_than(chd_pkg::CharLf));
      end
      END_DATA_NO_CR: begin
        push_size(2);
        push_crlf();
        push_payload(2);
        wire_bytes_q.push_back(byte_other_than(chd_pkg::CharCr));
      end
      END_DATA_NO_LF: begin
        push_size(2);
        push_crlf();
        push_payload(2);
        wire_bytes_q.push_back(chd_pkg::CharCr);
        wire_bytes_q.push_back(byte_other_than(chd_pkg::CharLf));
      end
      default: begin
        push_size(0);
        push_crlf();
        wire_bytes_q.push_back(byte_other_than(chd_pkg::CharCr));
      end
    endcase
    // bytes after the outcome must be ignored
    push_payload($urandom_range(8, 20));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (wire_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
